@@ src/hsm_pkg.sv @@
// Shared types and constants of the hierarchical state machine engine.
package hsm_pkg;

  localparam int NUM_STATES = 16;
  localparam logic [4:0] NO_STATE = 5'd16;
  localparam logic [15:0] USER_EVENT_MIN = 16'd1000;

  localparam logic [2:0] F_ADD_STATE = 3'd0;
  localparam logic [2:0] F_ADD_TRANS = 3'd1;
  localparam logic [2:0] F_SET_INIT = 3'd2;
  localparam logic [2:0] F_MARK_FINAL = 3'd3;
  localparam logic [2:0] F_START = 3'd4;
  localparam logic [2:0] F_STOP = 3'd5;
  localparam logic [2:0] F_POST = 3'd6;
  localparam logic [2:0] F_QUERY = 3'd7;

  localparam logic [2:0] K_EXIT = 3'd0;
  localparam logic [2:0] K_TRANS = 3'd1;
  localparam logic [2:0] K_ENTER = 3'd2;
  localparam logic [2:0] K_FINISH = 3'd3;
  localparam logic [2:0] K_DONE = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_RUN_STATE = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_BAD_ARG = 3'd3;
  localparam logic [2:0] ST_NO_MATCH = 3'd4;
  localparam logic [2:0] ST_CHAIN = 3'd5;

  localparam logic [1:0] CFG_INIT = 2'd0;
  localparam logic [1:0] CFG_FINAL = 2'd1;
  localparam logic [1:0] CFG_FIN_CODE = 2'd2;

  // state table lookup address source
  localparam logic [2:0] A_SID = 3'd0;
  localparam logic [2:0] A_TID = 3'd1;
  localparam logic [2:0] A_PID = 3'd2;
  localparam logic [2:0] A_WALK = 3'd3;
  localparam logic [2:0] A_INIT = 3'd4;
  localparam logic [2:0] A_TGT = 3'd5;

  // ancestor walk start
  localparam logic [1:0] W_CUR = 2'd0;
  localparam logic [1:0] W_PID = 2'd1;
  localparam logic [1:0] W_TGT = 2'd2;

  // result from_state source
  localparam logic [2:0] E_INIT = 3'd0;
  localparam logic [2:0] E_TGT = 3'd1;
  localparam logic [2:0] E_CUR = 3'd2;
  localparam logic [2:0] E_OLDC = 3'd3;
  localparam logic [2:0] E_NEWC = 3'd4;
  localparam logic [2:0] E_DONE = 3'd5;

  typedef struct packed {
    logic       ld_in;
    logic [2:0] asel;
    logic       set_status;
    logic [2:0] status;
    logic       add_state;
    logic       add_trans;
    logic       set_init;
    logic       set_final;
    logic       start;
    logic       stop;
    logic       walk_start;
    logic [1:0] walk_src;
    logic       walk_new;
    logic       walk_step;
    logic       walk_ans;
    logic       scan_start;
    logic       scan_step;
    logic       post_init;
    logic       chain_next;
    logic       take_move;
    logic       tgt_init;
    logic       cmp_clr;
    logic       cmp_step;
    logic       exit_start;
    logic       exit_step;
    logic       entry_start;
    logic       entry_step;
    logic       set_cur_tgt;
    logic       finish;
    logic       emit;
    logic [2:0] e_kind;
    logic [2:0] e_from;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       run;
    logic       lk_known;
    logic       lk_haskids;
    logic       lk_init_none;
    logic       lk_parent_eq_sid;
    logic       lk_final;
    logic       pid_none;
    logic       code_zero;
    logic       code_bad;
    logic       tcount_full;
    logic       walk_more;
    logic       walk_full;
    logic       scan_more;
    logic       found;
    logic       moves_zero;
    logic       moves_lim;
    logic       cur_is_tgt;
    logic       cmp_more;
    logic       exit_more;
    logic       entry_more;
    logic       cur_is_final;
    logic       out_free;
  } sts_t;

endpackage

@@ src/hsm_ram.sv @@
// Generic single-port-write RAM with registered read.
module hsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ src/hsm_datapath.sv @@
// Datapath: state table, transition memory, ancestor chains and result register.
module hsm_datapath #(
  parameter int NUM_TRANSITIONS = 32,
  parameter int MAX_DEPTH = 4,
  parameter int MAX_CHAIN = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  hsm_pkg::cmd_t cmd,
  output hsm_pkg::sts_t sts,
  input  logic [2:0]    in_tuser,
  input  logic [31:0]   in_tdata,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_wdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [15:0]   out_tdata,
  output logic [2:0]    out_tuser,
  output logic          out_tlast
);

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CW = $clog2(NUM_TRANSITIONS + 1);
  localparam int AW = (NUM_TRANSITIONS > 1) ? $clog2(NUM_TRANSITIONS) : 1;
  localparam int MW = $clog2(MAX_CHAIN + 1);
  localparam int NS = hsm_pkg::NUM_STATES;

  logic [2:0]  func_r;
  logic [3:0]  sid_r;
  logic [4:0]  pid_r;
  logic [15:0] code_r;
  logic [3:0]  tid_r;
  logic [15:0] evt_r;
  logic [4:0]  tgt_r;
  logic [4:0]  cur_r;
  logic        run_r;
  logic [2:0]  status_r;
  logic        ans_r;
  logic [4:0]  cfg_init_r;
  logic [4:0]  cfg_final_r;
  logic [15:0] cfg_fin_code_r;

  logic        valid_r [NS];
  logic [4:0]  parent_r [NS];
  logic [4:0]  init_r [NS];
  logic        haskids_r [NS];
  logic        final_r [NS];

  logic [CW-1:0] tcount_r;
  logic [CW-1:0] scan_i_r;
  logic          found_r;
  logic [IW-1:0] best_lvl_r;
  logic [3:0]    best_tgt_r;
  logic [MW-1:0] moves_r;

  logic [4:0]    oldc_r [MAX_DEPTH];
  logic [4:0]    newc_r [MAX_DEPTH];
  logic [DW-1:0] on_r;
  logic [DW-1:0] nn_r;
  logic [4:0]    w_ptr_r;
  logic          w_new_r;
  logic [DW-1:0] cnt_r;
  logic [DW-1:0] c_r;

  logic          out_valid_r;
  logic [2:0]    out_kind_r;
  logic [4:0]    out_from_r;
  logic [4:0]    out_to_r;
  logic [2:0]    out_status_r;
  logic          out_ans_r;
  logic          out_last_r;

  logic [4:0]  lk_addr;
  logic [3:0]  lk_idx;
  logic        lk_known;
  logic [DW-1:0] w_len;
  logic [23:0] ram_rdata;
  logic [3:0]  r_from;
  logic [15:0] r_event;
  logic [3:0]  r_target;
  logic        lvl_hit;
  logic [IW-1:0] lvl;
  logic [DW-1:0] oi;
  logic [DW-1:0] ni;
  logic [DW-1:0] cm1;
  logic [4:0]  e_from_val;
  logic        out_free;

  always_comb begin
    case (cmd.asel)
      hsm_pkg::A_SID:  lk_addr = {1'b0, sid_r};
      hsm_pkg::A_TID:  lk_addr = {1'b0, tid_r};
      hsm_pkg::A_PID:  lk_addr = pid_r;
      hsm_pkg::A_WALK: lk_addr = w_ptr_r;
      hsm_pkg::A_INIT: lk_addr = cfg_init_r;
      hsm_pkg::A_TGT:  lk_addr = tgt_r;
      default:         lk_addr = hsm_pkg::NO_STATE;
    endcase
  end

  assign lk_idx   = lk_addr[3:0];
  assign lk_known = (lk_addr < hsm_pkg::NO_STATE) && valid_r[lk_idx];
  assign w_len    = w_new_r ? nn_r : on_r;

  assign r_from   = ram_rdata[23:20];
  assign r_event  = ram_rdata[19:4];
  assign r_target = ram_rdata[3:0];

  always_comb begin
    lvl_hit = 1'b0;
    lvl     = '0;
    for (int j = MAX_DEPTH - 1; j >= 0; j--) begin
      if ((DW'(j) < on_r) && (oldc_r[j] == {1'b0, r_from})) begin
        lvl_hit = 1'b1;
        lvl     = IW'(j);
      end
    end
  end

  assign oi  = on_r - DW'(1) - cnt_r;
  assign ni  = nn_r - DW'(1) - cnt_r;
  assign cm1 = cnt_r - DW'(1);

  always_comb begin
    case (cmd.e_from)
      hsm_pkg::E_INIT: e_from_val = cfg_init_r;
      hsm_pkg::E_TGT:  e_from_val = tgt_r;
      hsm_pkg::E_CUR:  e_from_val = cur_r;
      hsm_pkg::E_OLDC: e_from_val = oldc_r[cnt_r[IW-1:0]];
      hsm_pkg::E_NEWC: e_from_val = newc_r[cm1[IW-1:0]];
      hsm_pkg::E_DONE: e_from_val = run_r ? cur_r : hsm_pkg::NO_STATE;
      default:         e_from_val = hsm_pkg::NO_STATE;
    endcase
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    sts.func             = func_r;
    sts.run              = run_r;
    sts.lk_known         = lk_known;
    sts.lk_haskids       = haskids_r[lk_idx];
    sts.lk_init_none     = (init_r[lk_idx] == hsm_pkg::NO_STATE);
    sts.lk_parent_eq_sid = (parent_r[lk_idx] == {1'b0, sid_r});
    sts.lk_final         = final_r[lk_idx];
    sts.pid_none         = (pid_r == hsm_pkg::NO_STATE);
    sts.code_zero        = (code_r == 16'd0);
    sts.code_bad         = (code_r != cfg_fin_code_r) && (code_r < hsm_pkg::USER_EVENT_MIN);
    sts.tcount_full      = (tcount_r >= CW'(NUM_TRANSITIONS));
    sts.walk_more        = lk_known && (w_len < DW'(MAX_DEPTH));
    sts.walk_full        = (w_len >= DW'(MAX_DEPTH));
    sts.scan_more        = (scan_i_r < tcount_r);
    sts.found            = found_r;
    sts.moves_zero       = (moves_r == '0);
    sts.moves_lim        = (moves_r >= MW'(MAX_CHAIN));
    sts.cur_is_tgt       = (cur_r == tgt_r);
    sts.cmp_more         = (cnt_r < on_r) && (cnt_r < nn_r) &&
                           (oldc_r[oi[IW-1:0]] == newc_r[ni[IW-1:0]]);
    sts.exit_more        = (cnt_r < (on_r - c_r));
    sts.entry_more       = (cnt_r != '0);
    sts.cur_is_final     = (cur_r == cfg_final_r);
    sts.out_free         = out_free;
  end

  hsm_ram #(
    .WIDTH (24),
    .DEPTH (NUM_TRANSITIONS)
  ) u_trans_ram (
    .clk   (clk),
    .we    (cmd.add_trans),
    .waddr (tcount_r[AW-1:0]),
    .wdata ({sid_r, code_r, tid_r}),
    .raddr (scan_i_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        valid_r[i] <= 1'b0;
      end
      tcount_r       <= '0;
      cur_r          <= hsm_pkg::NO_STATE;
      run_r          <= 1'b0;
      cfg_init_r     <= hsm_pkg::NO_STATE;
      cfg_final_r    <= hsm_pkg::NO_STATE;
      cfg_fin_code_r <= 16'd999;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hsm_pkg::CFG_INIT:     cfg_init_r <= cfg_wdata[4:0];
          hsm_pkg::CFG_FINAL:    cfg_final_r <= cfg_wdata[4:0];
          hsm_pkg::CFG_FIN_CODE: cfg_fin_code_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.add_state) begin
        valid_r[sid_r] <= 1'b1;
      end
      if (cmd.add_trans) begin
        tcount_r <= tcount_r + CW'(1);
      end
      if (cmd.start) begin
        cur_r <= cfg_init_r;
        run_r <= 1'b1;
      end else if (cmd.stop || cmd.finish) begin
        cur_r <= hsm_pkg::NO_STATE;
        run_r <= 1'b0;
      end else if (cmd.set_cur_tgt) begin
        cur_r <= tgt_r;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      func_r   <= in_tuser;
      sid_r    <= in_tdata[3:0];
      pid_r    <= in_tdata[8:4];
      code_r   <= in_tdata[24:9];
      tid_r    <= in_tdata[28:25];
      status_r <= hsm_pkg::ST_OK;
      ans_r    <= 1'b0;
    end else begin
      if (cmd.set_status) begin
        status_r <= cmd.status;
      end
      if (cmd.walk_step && cmd.walk_ans && (w_ptr_r == {1'b0, sid_r})) begin
        ans_r <= 1'b1;
      end
    end
    if (cmd.add_state) begin
      parent_r[sid_r]  <= pid_r;
      init_r[sid_r]    <= hsm_pkg::NO_STATE;
      haskids_r[sid_r] <= 1'b0;
      final_r[sid_r]   <= 1'b0;
      if (pid_r != hsm_pkg::NO_STATE) begin
        haskids_r[pid_r[3:0]] <= 1'b1;
      end
    end
    if (cmd.set_init) begin
      init_r[sid_r] <= {1'b0, tid_r};
    end
    if (cmd.set_final) begin
      final_r[tid_r] <= 1'b1;
    end
    if (cmd.walk_start) begin
      w_new_r <= cmd.walk_new;
      case (cmd.walk_src)
        hsm_pkg::W_PID: w_ptr_r <= pid_r;
        hsm_pkg::W_TGT: w_ptr_r <= tgt_r;
        default:        w_ptr_r <= cur_r;
      endcase
      if (cmd.walk_new) begin
        nn_r <= '0;
      end else begin
        on_r <= '0;
      end
    end else if (cmd.walk_step) begin
      w_ptr_r <= parent_r[lk_idx];
      if (w_new_r) begin
        newc_r[nn_r[IW-1:0]] <= w_ptr_r;
        nn_r <= nn_r + DW'(1);
      end else begin
        oldc_r[on_r[IW-1:0]] <= w_ptr_r;
        on_r <= on_r + DW'(1);
      end
    end
    if (cmd.post_init) begin
      evt_r   <= code_r;
      moves_r <= '0;
    end else if (cmd.chain_next) begin
      evt_r <= cfg_fin_code_r;
    end else if (cmd.take_move) begin
      moves_r <= moves_r + MW'(1);
    end
    if (cmd.scan_start) begin
      scan_i_r <= '0;
      found_r  <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_i_r <= scan_i_r + CW'(1);
      if ((r_event == evt_r) && lvl_hit && (!found_r || (lvl < best_lvl_r))) begin
        found_r    <= 1'b1;
        best_lvl_r <= lvl;
        best_tgt_r <= r_target;
      end
    end
    if (cmd.take_move) begin
      tgt_r <= {1'b0, best_tgt_r};
    end else if (cmd.tgt_init) begin
      tgt_r <= init_r[lk_idx];
    end
    if (cmd.cmp_clr) begin
      cnt_r <= '0;
    end else if (cmd.cmp_step || cmd.exit_step) begin
      cnt_r <= cnt_r + DW'(1);
    end else if (cmd.exit_start) begin
      c_r   <= cnt_r;
      cnt_r <= '0;
    end else if (cmd.entry_start) begin
      cnt_r <= nn_r - c_r;
    end else if (cmd.entry_step) begin
      cnt_r <= cm1;
    end
    if (cmd.emit) begin
      out_kind_r   <= cmd.e_kind;
      out_from_r   <= e_from_val;
      out_to_r     <= (cmd.e_kind == hsm_pkg::K_TRANS) ? tgt_r : hsm_pkg::NO_STATE;
      out_status_r <= (cmd.e_kind == hsm_pkg::K_DONE) ? status_r : hsm_pkg::ST_OK;
      out_ans_r    <= (cmd.e_kind == hsm_pkg::K_DONE) && ans_r;
      out_last_r   <= (cmd.e_kind == hsm_pkg::K_DONE);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {2'b00, out_ans_r, out_status_r, out_to_r, out_from_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_stopped_no_state: assert property (@(posedge clk) disable iff (!rst_n)
    !run_r |-> (cur_r == hsm_pkg::NO_STATE))
    else $error("stopped engine holds a current state");
  a_tcount_range: assert property (@(posedge clk) disable iff (!rst_n)
    tcount_r <= CW'(NUM_TRANSITIONS))
    else $error("transition count beyond table");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("result overwritten before delivery");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step |-> (w_len < DW'(MAX_DEPTH)))
    else $error("ancestor walk past depth limit");
`endif

endmodule

@@ src/hsm_ctrl.sv @@
// Controller state machine sequencing each command and event transaction.
module hsm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  hsm_pkg::sts_t sts,
  output hsm_pkg::cmd_t cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_ADD_P   = 5'd2;
  localparam logic [4:0] S_ADD_W   = 5'd3;
  localparam logic [4:0] S_AT_S    = 5'd4;
  localparam logic [4:0] S_AT_T    = 5'd5;
  localparam logic [4:0] S_CF_S    = 5'd6;
  localparam logic [4:0] S_CF_T    = 5'd7;
  localparam logic [4:0] S_START   = 5'd8;
  localparam logic [4:0] S_FIND_W  = 5'd9;
  localparam logic [4:0] S_SCAN_RD = 5'd10;
  localparam logic [4:0] S_SCAN_EV = 5'd11;
  localparam logic [4:0] S_FOUND   = 5'd12;
  localparam logic [4:0] S_MV      = 5'd13;
  localparam logic [4:0] S_MV2     = 5'd14;
  localparam logic [4:0] S_SELF_X  = 5'd15;
  localparam logic [4:0] S_SELF_T  = 5'd16;
  localparam logic [4:0] S_SELF_E  = 5'd17;
  localparam logic [4:0] S_NEWW    = 5'd18;
  localparam logic [4:0] S_CMP     = 5'd19;
  localparam logic [4:0] S_EXIT    = 5'd20;
  localparam logic [4:0] S_TRANS   = 5'd21;
  localparam logic [4:0] S_ENTRY   = 5'd22;
  localparam logic [4:0] S_FINCHK  = 5'd23;
  localparam logic [4:0] S_FINISH  = 5'd24;
  localparam logic [4:0] S_DONE    = 5'd25;
  localparam logic [4:0] S_QW      = 5'd26;

  logic [4:0] state_r;
  logic [4:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_DONE;
        if ((sts.func <= hsm_pkg::F_MARK_FINAL) && sts.run) begin
          cmd.set_status = 1'b1;
          cmd.status     = hsm_pkg::ST_RUN_STATE;
        end else begin
          case (sts.func)
            hsm_pkg::F_ADD_STATE: begin
              cmd.asel = hsm_pkg::A_SID;
              if (sts.lk_known) begin
                cmd.set_status = 1'b1;
                cmd.status     = hsm_pkg::ST_BAD_ARG;
              end else if (sts.pid_none) begin
                cmd.add_state = 1'b1;
              end else begin
                state_nxt = S_ADD_P;
              end
            end
            hsm_pkg::F_ADD_TRANS: begin
              if (sts.code_zero) begin
                cmd.set_status = 1'b1;
                cmd.status     = hsm_pkg::ST_BAD_ARG;
              end else begin
                state_nxt = S_AT_S;
              end
            end
            hsm_pkg::F_SET_INIT, hsm_pkg::F_MARK_FINAL: begin
              state_nxt = S_CF_S;
            end
            hsm_pkg::F_START: begin
              cmd.asel = hsm_pkg::A_INIT;
              if (sts.run) begin
                cmd.set_status = 1'b1;
                cmd.status     = hsm_pkg::ST_RUN_STATE;
              end else if (!sts.lk_known) begin
                cmd.set_status = 1'b1;
                cmd.status     = hsm_pkg::ST_UNKNOWN;
              end else begin
                state_nxt = S_START;
              end
            end
            hsm_pkg::F_STOP: begin
              if (!sts.run) begin
                cmd.set_status = 1'b1;
                cmd.status     = hsm_pkg::ST_RUN_STATE;
              end else begin
                cmd.stop = 1'b1;
              end
            end
            hsm_pkg::F_POST: begin
              if (!sts.run) begin
                cmd.set_status = 1'b1;
                cmd.status     = hsm_pkg::ST_RUN_STATE;
              end else if (sts.code_bad) begin
                cmd.set_status = 1'b1;
                cmd.status     = hsm_pkg::ST_BAD_ARG;
              end else begin
                cmd.post_init  = 1'b1;
                cmd.walk_start = 1'b1;
                cmd.walk_src   = hsm_pkg::W_CUR;
                state_nxt      = S_FIND_W;
              end
            end
            default: begin
              if (!sts.run) begin
                cmd.set_status = 1'b1;
                cmd.status     = hsm_pkg::ST_RUN_STATE;
              end else begin
                cmd.walk_start = 1'b1;
                cmd.walk_src   = hsm_pkg::W_CUR;
                state_nxt      = S_QW;
              end
            end
          endcase
        end
      end
      S_ADD_P: begin
        cmd.asel  = hsm_pkg::A_PID;
        state_nxt = S_DONE;
        if (!sts.lk_known) begin
          cmd.set_status = 1'b1;
          cmd.status     = hsm_pkg::ST_UNKNOWN;
        end else begin
          cmd.walk_start = 1'b1;
          cmd.walk_src   = hsm_pkg::W_PID;
          state_nxt      = S_ADD_W;
        end
      end
      S_ADD_W: begin
        cmd.asel = hsm_pkg::A_WALK;
        if (sts.walk_more) begin
          cmd.walk_step = 1'b1;
        end else begin
          state_nxt = S_DONE;
          if (sts.walk_full) begin
            cmd.set_status = 1'b1;
            cmd.status     = hsm_pkg::ST_BAD_ARG;
          end else begin
            cmd.add_state = 1'b1;
          end
        end
      end
      S_AT_S: begin
        cmd.asel = hsm_pkg::A_SID;
        if (!sts.lk_known) begin
          cmd.set_status = 1'b1;
          cmd.status     = hsm_pkg::ST_UNKNOWN;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_AT_T;
        end
      end
      S_AT_T: begin
        cmd.asel  = hsm_pkg::A_TID;
        state_nxt = S_DONE;
        if (!sts.lk_known) begin
          cmd.set_status = 1'b1;
          cmd.status     = hsm_pkg::ST_UNKNOWN;
        end else if ((sts.lk_haskids && sts.lk_init_none) || sts.tcount_full) begin
          cmd.set_status = 1'b1;
          cmd.status     = hsm_pkg::ST_BAD_ARG;
        end else begin
          cmd.add_trans = 1'b1;
        end
      end
      S_CF_S: begin
        cmd.asel = hsm_pkg::A_SID;
        if (!sts.lk_known) begin
          cmd.set_status = 1'b1;
          cmd.status     = hsm_pkg::ST_UNKNOWN;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_CF_T;
        end
      end
      S_CF_T: begin
        cmd.asel  = hsm_pkg::A_TID;
        state_nxt = S_DONE;
        if (!sts.lk_known) begin
          cmd.set_status = 1'b1;
          cmd.status     = hsm_pkg::ST_UNKNOWN;
        end else if (!sts.lk_parent_eq_sid) begin
          cmd.set_status = 1'b1;
          cmd.status     = hsm_pkg::ST_BAD_ARG;
        end else if (sts.func == hsm_pkg::F_SET_INIT) begin
          cmd.set_init = 1'b1;
        end else begin
          cmd.set_final = 1'b1;
        end
      end
      S_START: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.e_kind = hsm_pkg::K_ENTER;
          cmd.e_from = hsm_pkg::E_INIT;
          cmd.start  = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_FIND_W: begin
        cmd.asel = hsm_pkg::A_WALK;
        if (sts.walk_more) begin
          cmd.walk_step = 1'b1;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_nxt = sts.scan_more ? S_SCAN_EV : S_FOUND;
      end
      S_SCAN_EV: begin
        cmd.scan_step = 1'b1;
        state_nxt     = S_SCAN_RD;
      end
      S_FOUND: begin
        state_nxt = S_DONE;
        if (!sts.found) begin
          if (sts.moves_zero) begin
            cmd.set_status = 1'b1;
            cmd.status     = hsm_pkg::ST_NO_MATCH;
          end
        end else if (sts.moves_lim) begin
          cmd.set_status = 1'b1;
          cmd.status     = hsm_pkg::ST_CHAIN;
        end else begin
          cmd.take_move = 1'b1;
          state_nxt     = S_MV;
        end
      end
      S_MV: begin
        cmd.asel = hsm_pkg::A_TGT;
        if (sts.cur_is_tgt) begin
          state_nxt = S_SELF_X;
        end else if (sts.lk_haskids) begin
          if (sts.lk_init_none) begin
            cmd.set_status = 1'b1;
            cmd.status     = hsm_pkg::ST_BAD_ARG;
            state_nxt      = S_DONE;
          end else begin
            cmd.tgt_init = 1'b1;
            state_nxt    = S_MV2;
          end
        end else begin
          cmd.walk_start = 1'b1;
          cmd.walk_src   = hsm_pkg::W_TGT;
          cmd.walk_new   = 1'b1;
          state_nxt      = S_NEWW;
        end
      end
      S_MV2: begin
        cmd.walk_start = 1'b1;
        cmd.walk_src   = hsm_pkg::W_TGT;
        cmd.walk_new   = 1'b1;
        state_nxt      = S_NEWW;
      end
      S_SELF_X: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.e_kind = hsm_pkg::K_EXIT;
          cmd.e_from = hsm_pkg::E_TGT;
          state_nxt  = S_SELF_T;
        end
      end
      S_SELF_T: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.e_kind = hsm_pkg::K_TRANS;
          cmd.e_from = hsm_pkg::E_CUR;
          state_nxt  = S_SELF_E;
        end
      end
      S_SELF_E: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.e_kind = hsm_pkg::K_ENTER;
          cmd.e_from = hsm_pkg::E_TGT;
          state_nxt  = S_FINCHK;
        end
      end
      S_NEWW: begin
        cmd.asel = hsm_pkg::A_WALK;
        if (sts.walk_more) begin
          cmd.walk_step = 1'b1;
        end else begin
          cmd.cmp_clr = 1'b1;
          state_nxt   = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.cmp_more) begin
          cmd.cmp_step = 1'b1;
        end else begin
          cmd.exit_start = 1'b1;
          state_nxt      = S_EXIT;
        end
      end
      S_EXIT: begin
        if (!sts.exit_more) begin
          state_nxt = S_TRANS;
        end else if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.e_kind    = hsm_pkg::K_EXIT;
          cmd.e_from    = hsm_pkg::E_OLDC;
          cmd.exit_step = 1'b1;
        end
      end
      S_TRANS: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.e_kind      = hsm_pkg::K_TRANS;
          cmd.e_from      = hsm_pkg::E_CUR;
          cmd.set_cur_tgt = 1'b1;
          cmd.entry_start = 1'b1;
          state_nxt       = S_ENTRY;
        end
      end
      S_ENTRY: begin
        if (!sts.entry_more) begin
          state_nxt = S_FINCHK;
        end else if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.e_kind     = hsm_pkg::K_ENTER;
          cmd.e_from     = hsm_pkg::E_NEWC;
          cmd.entry_step = 1'b1;
        end
      end
      S_FINCHK: begin
        cmd.asel = hsm_pkg::A_TGT;
        if (sts.cur_is_final) begin
          state_nxt = S_FINISH;
        end else if (sts.lk_final) begin
          cmd.chain_next = 1'b1;
          cmd.walk_start = 1'b1;
          cmd.walk_src   = hsm_pkg::W_CUR;
          state_nxt      = S_FIND_W;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.e_kind = hsm_pkg::K_FINISH;
          cmd.e_from = hsm_pkg::E_CUR;
          cmd.finish = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_QW: begin
        cmd.asel = hsm_pkg::A_WALK;
        if (sts.walk_more) begin
          cmd.walk_step = 1'b1;
          cmd.walk_ans  = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.e_kind = hsm_pkg::K_DONE;
          cmd.e_from = hsm_pkg::E_DONE;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ src/hierarchical_state_machine_engine.sv @@
// Top level of the hierarchical state machine engine.
//
// Channel  Direction  Transaction
// in_      slave      one command or event: tuser = func, tdata = fields
// out_     master     one result item: tuser = kind, tlast on the done item
// cfg_     write      one register write: index, data
//
// One transaction at a time; table commands check their arguments after the
// accept, and a child state or a query also walks the ancestor chain.
// A posted event takes per move two ancestor walks and a chain compare, a
// scan of every stored transition, one result item per exit, transition and
// entry, and the control states around them, for up to MAX_CHAIN moves.
// Reset is synchronous: state table empty, machine stopped. A stalled out_
// holds the controller; in_tready is low until the done item has been loaded.
module hierarchical_state_machine_engine #(
  parameter int NUM_TRANSITIONS = 32,
  parameter int MAX_DEPTH = 4,
  parameter int MAX_CHAIN = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // state_id, parent_id, event_code, target_id
  input  logic [2:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // from_state, to_state, status, answer
  output logic [2:0]  out_tuser,  // kind
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  hsm_pkg::cmd_t cmd;
  hsm_pkg::sts_t sts;

  hsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hsm_datapath #(
    .NUM_TRANSITIONS (NUM_TRANSITIONS),
    .MAX_DEPTH       (MAX_DEPTH),
    .MAX_CHAIN       (MAX_CHAIN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
